### rtl/dkis_pkg.sv
// Shared types, constants and key-ordering function of the descending key index sorter.
`default_nettype none
package dkis_pkg;

	localparam int KEY_W     = 32;
	localparam int SRC_IDX_W = 6;
	localparam int LIMIT_W   = 7;
	localparam int APB_W     = 32;
	localparam int ADDR_W    = 3;

	// Word index of each configuration register (byte address 4 * index).
	localparam logic [ADDR_W-3:0] REG_SORT_LIMIT = '0;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_KEY,
		ST_SWEEP,
		ST_WRITE,
		ST_OUT_RD,
		ST_OUT_SHOW
	} dkis_state_t;

	// Maps a single-precision bit pattern to an unsigned rank with the same order
	// as the float value. Both zeros share one rank and every NaN ranks lowest.
	function automatic logic [KEY_W-1:0] key_rank(input logic [KEY_W-1:0] k);
		logic [KEY_W-2:0] mag;
		logic [KEY_W-1:0] r;
		mag = k[KEY_W-2:0];
		if (mag > 31'h7F80_0000) begin
			r = '0;
		end else if (mag == '0) begin
			r = 32'h8000_0000;
		end else if (k[KEY_W-1]) begin
			r = ~k;
		end else begin
			r = k | 32'h8000_0000;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/dkis_in_if.sv
// Record input channel: valid/ready handshake carrying one key and the group end mark.
`default_nettype none
interface dkis_in_if;
	import dkis_pkg::*;

	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] pt_key;
	logic             last_item;

	modport source (output valid, output pt_key, output last_item, input ready);
	modport sink   (input valid, input pt_key, input last_item, output ready);
endinterface
`default_nettype wire

### rtl/dkis_out_if.sv
// Result output channel: valid/ready handshake carrying one sorted record.
`default_nettype none
interface dkis_out_if;
	import dkis_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [SRC_IDX_W-1:0] source_index;
	logic [KEY_W-1:0]     sorted_key;
	logic                 last_result;
	logic                 overflow;

	modport source (output valid, output source_index, output sorted_key,
		output last_result, output overflow, input ready);
	modport sink   (input valid, input source_index, input sorted_key,
		input last_result, input overflow, output ready);
endinterface
`default_nettype wire

### rtl/dkis_cfg.sv
// APB register block holding the sort length limit.
`default_nettype none
module dkis_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [dkis_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [dkis_pkg::APB_W-1:0]   pwdata,
	output logic      [dkis_pkg::APB_W-1:0]   prdata,
	output logic                              pready,
	output logic      [dkis_pkg::LIMIT_W-1:0] sort_limit
);
	import dkis_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic               hit;

	assign hit    = (paddr[ADDR_W-1:2] == REG_SORT_LIMIT);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (psel && penable && pwrite && pready && hit) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	assign prdata     = hit ? APB_W'(limit_q) : '0;
	assign sort_limit = limit_q;
endmodule
`default_nettype wire

### rtl/descending_key_index_sorter_top.sv
// Top level of the descending key index sorter: record store, sort sequencer and output.
`default_nettype none
// Records enter one per cycle into the key memory until one arrives with last_item set; records
// past DEPTH are dropped and every result of that group shows overflow. The sort region (the
// sort_limit register if it lies between 1 and count-1, else the count capped at SORT_CAP) is
// then ranked: for each record of the region the sequencer sweeps the region once
// through the single read port of the key memory and counts the records that go ahead of it
// (greater float value, or equal and earlier), then writes key and arrival index to that slot of
// the sorted memory. Output then reads one memory entry per result in a read state and offers
// it in a show state until it is taken. No record is taken from the end of a group until its
// last result has left.
module descending_key_index_sorter_top #(
	parameter int DEPTH    = 64,
	parameter int SORT_CAP = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	dkis_in_if.sink                           in_ch,
	dkis_out_if.source                        out_ch,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [dkis_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [dkis_pkg::APB_W-1:0]   pwdata,
	output logic      [dkis_pkg::APB_W-1:0]   prdata,
	output logic                              pready
);
	import dkis_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CAP_W = $clog2(SORT_CAP + 1);
	localparam int CW0   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int CW    = (CW0 > CAP_W) ? CW0 : CAP_W;

	logic [LIMIT_W-1:0] sort_limit;

	dkis_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.sort_limit (sort_limit)
	);

	dkis_state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q;
	logic             drop_q;
	logic             grp_drop_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] region_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] p_q;
	logic [CNT_W-1:0] pos_q;
	logic [KEY_W-1:0] key_i_q;
	logic [KEY_W-1:0] rank_i_q;

	logic [KEY_W-1:0] src_mem [DEPTH];
	logic [KEY_W-1:0] dst_key_mem [DEPTH];
	logic [IDX_W-1:0] dst_idx_mem [DEPTH];
	logic [KEY_W-1:0] src_rdata_q;
	logic [KEY_W-1:0] dst_key_q;
	logic [IDX_W-1:0] dst_idx_q;

	logic             in_fire, out_fire;
	logic             room;
	logic             src_we, dst_we;
	logic [IDX_W-1:0] src_raddr;
	logic [CNT_W-1:0] n_next;
	logic [CW-1:0]    n_w, lim_w, region_w;
	logic [KEY_W-1:0] rank_j;
	logic             ahead;
	logic             use_dst;
	logic [IDX_W-1:0] out_idx;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;
	assign room     = (cnt_q < CNT_W'(DEPTH));
	assign n_next   = room ? cnt_q + 1'b1 : cnt_q;

	// Region length for the group that ends with the current request.
	always_comb begin
		n_w   = CW'(n_next);
		lim_w = CW'(sort_limit);
		if (lim_w != '0 && lim_w < n_w) begin
			region_w = lim_w;
		end else if (n_w < CW'(SORT_CAP)) begin
			region_w = n_w;
		end else begin
			region_w = CW'(SORT_CAP);
		end
	end

	// A record at sweep position j-1 goes ahead of record i if it ranks higher,
	// or ranks equal and arrived earlier.
	assign rank_j = key_rank(src_rdata_q);
	assign ahead  = (rank_j > rank_i_q) || ((rank_j == rank_i_q) && (j_q <= i_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_fire && in_ch.last_item) state_d = ST_FETCH;
			end
			ST_FETCH: state_d = ST_KEY;
			ST_KEY:   state_d = ST_SWEEP;
			ST_SWEEP: begin
				if (j_q == region_q) state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (i_q + 1'b1 == region_q) state_d = ST_OUT_RD;
				else state_d = ST_FETCH;
			end
			ST_OUT_RD: state_d = ST_OUT_SHOW;
			ST_OUT_SHOW: begin
				if (out_fire) state_d = out_ch.last_result ? ST_LOAD : ST_OUT_RD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ch.ready  = 1'b0;
		out_ch.valid = 1'b0;
		src_we       = 1'b0;
		dst_we       = 1'b0;
		src_raddr    = p_q[IDX_W-1:0];
		unique case (state_q)
			ST_LOAD: begin
				in_ch.ready = 1'b1;
				src_we      = in_fire && room;
			end
			ST_FETCH:    src_raddr = i_q[IDX_W-1:0];
			ST_KEY:      src_raddr = '0;
			ST_SWEEP:    src_raddr = j_q[IDX_W-1:0];
			ST_WRITE:    dst_we = 1'b1;
			ST_OUT_RD:   src_raddr = p_q[IDX_W-1:0];
			ST_OUT_SHOW: out_ch.valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_q      <= '0;
			drop_q     <= 1'b0;
			grp_drop_q <= 1'b0;
			n_q        <= '0;
			region_q   <= '0;
			i_q        <= '0;
			j_q        <= '0;
			p_q        <= '0;
			pos_q      <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (in_ch.last_item) begin
							n_q        <= n_next;
							region_q   <= CNT_W'(region_w);
							grp_drop_q <= drop_q || !room;
							cnt_q      <= '0;
							drop_q     <= 1'b0;
							i_q        <= '0;
						end else begin
							cnt_q  <= n_next;
							drop_q <= drop_q || !room;
						end
					end
				end
				ST_KEY: begin
					j_q   <= CNT_W'(1);
					pos_q <= '0;
				end
				ST_SWEEP: begin
					if (ahead) pos_q <= pos_q + 1'b1;
					if (j_q != region_q) j_q <= j_q + 1'b1;
				end
				ST_WRITE: begin
					i_q <= i_q + 1'b1;
					p_q <= '0;
				end
				ST_OUT_SHOW: begin
					if (out_fire) p_q <= p_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_KEY) begin
			key_i_q  <= src_rdata_q;
			rank_i_q <= key_rank(src_rdata_q);
		end
	end

	always_ff @(posedge clk) begin
		if (src_we) src_mem[cnt_q[IDX_W-1:0]] <= in_ch.pt_key;
		src_rdata_q <= src_mem[src_raddr];
	end

	always_ff @(posedge clk) begin
		if (dst_we) begin
			dst_key_mem[pos_q[IDX_W-1:0]] <= key_i_q;
			dst_idx_mem[pos_q[IDX_W-1:0]] <= i_q[IDX_W-1:0];
		end
		dst_key_q <= dst_key_mem[p_q[IDX_W-1:0]];
		dst_idx_q <= dst_idx_mem[p_q[IDX_W-1:0]];
	end

	// Past the sort region records leave unchanged, straight from the key memory.
	assign use_dst             = (p_q < region_q);
	assign out_idx             = use_dst ? dst_idx_q : p_q[IDX_W-1:0];
	assign out_ch.sorted_key   = use_dst ? dst_key_q : src_rdata_q;
	assign out_ch.source_index = SRC_IDX_W'(out_idx);
	assign out_ch.last_result  = (p_q == n_q - 1'b1);
	assign out_ch.overflow     = grp_drop_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input taken while a result is offered");

	a_slot_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> (pos_q < region_q))
		else $error("sorted slot outside the sort region");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CNT_W'(DEPTH)) && (region_q <= n_q))
		else $error("record count or region out of range");

	a_group_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && out_ch.last_result) |=> (in_ch.ready && cnt_q == '0 && !drop_q))
		else $error("group end did not return to loading");

	a_store_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_ch.last_item) |=> (state_q == ST_FETCH && region_q != '0))
		else $error("group end did not start the sort");
endmodule
`default_nettype wire
